// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the oscillator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ON_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a consequence in the next one
`define ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/fmwv_pkg.sv -----
// ----------------------------------------------------------------------------
// fmwv_pkg
// Types, field widths and defaults of the fm wavetable voice oscillator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmwv_pkg;

  // field widths
  localparam int KIND_W     = 2;
  localparam int VOICE_W    = 4;
  localparam int FM_W       = 16;
  localparam int RATIO_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int BASE_W     = 26;
  localparam int VOL_W      = 16;
  localparam int FMS_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;

  // register reset values
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(65536);

  // parameter defaults
  localparam int VOICES_DEF     = 16;
  localparam int TABLE_SIZE_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 16;

  // sine table generation, q30 taylor series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
  localparam logic [63:0] SIN_DENOM [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_INC = 2'd0,
    REG_VOLUME   = 2'd1,
    REG_FM_SCALE = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_ROM,
    S_INTERP,
    S_SUM,
    S_SCALE,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/fmwv_ram.sv -----
// ----------------------------------------------------------------------------
// fmwv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmwv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fm_wavetable_voice_oscillator.sv -----
// ----------------------------------------------------------------------------
// fm_wavetable_voice_oscillator
// Per-voice sine wavetable oscillator with fm and linear interpolation.
// ----------------------------------------------------------------------------
// Items are handled one at a time by a small sequencer around one voice RAM
// that holds {step, phase} per voice; a valid bit per voice makes a voice
// that was never started or was ended read as zero phase and zero step, so
// no clearing pass is needed after reset. A sample item runs store read,
// phase update and write back, sine table lookup, interpolation multiply,
// sum, volume multiply and saturation into the output register before the
// next item is accepted; with zero volume or an out of range voice it skips
// from the store read to the output step, which waits only while the output
// register still holds an untaken result. A start item does the step multiply,
// then the store write; an end item or an unused kind needs no further state.
// TABLE_SIZE must be a power of two; the sine table keeps a quarter wave of
// TABLE_SIZE/4+1 entries built at elaboration. cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fm_wavetable_voice_oscillator #(
  parameter int VOICES     = fmwv_pkg::VOICES_DEF,
  parameter int TABLE_SIZE = fmwv_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = fmwv_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [fmwv_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [fmwv_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // input items
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [fmwv_pkg::KIND_W-1:0]             kind_i,
  input  logic [fmwv_pkg::VOICE_W-1:0]            voice_i,
  input  logic signed [fmwv_pkg::FM_W-1:0]        freq_mod_i,
  input  logic [fmwv_pkg::RATIO_W-1:0]            voice_ratio_i,
  // results
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [fmwv_pkg::SAMPLE_W-1:0]    sample_o,
  output logic [fmwv_pkg::VOICE_W-1:0]            voice_out_o
);

  import fmwv_pkg::*;

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int L     = $clog2(TABLE_SIZE);
  localparam int PW    = L + FRAC_BITS;
  localparam int QN    = TABLE_SIZE / 4;
  localparam int FMP_W = FM_W + FMS_W + 1;
  localparam int OW    = FMP_W - 15;
  localparam int XW    = (PW > OW) ? PW : OW;
  localparam int STP_W = BASE_W + RATIO_W;
  localparam int SHW   = STP_W - 8;
  localparam int IP_W  = SAMPLE_W + 1 + FRAC_BITS + 1;
  localparam int Y_W   = SAMPLE_W + VOL_W + 1;
  localparam logic [L-2:0] QN_IDX = (L-1)'(QN);

  // quarter-wave sine magnitude for table position j of the full wave
  function automatic logic [SAMPLE_W-2:0] quarter_entry(int unsigned j);
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sv;
    logic signed [63:0] sum;
    rem  = 64'(4 * j);
    x    = (rem * HALF_PI_Q30) / 64'(TABLE_SIZE);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / SIN_DENOM[k-1];
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    sv = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (sv > 64'd32767) begin
      sv = 64'd32767;
    end
    return sv[SAMPLE_W-2:0];
  endfunction

  logic [SAMPLE_W-2:0] quarter_tbl [QN+1];

  for (genvar g = 0; g <= QN; g++) begin : g_qtbl
    localparam logic [SAMPLE_W-2:0] QV = quarter_entry(g);
    assign quarter_tbl[g] = QV;
  end

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0] base_q;
  logic [VOL_W-1:0]  vol_q;
  logic [FMS_W-1:0]  fms_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      vol_q  <= '0;
      fms_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BASE_INC: base_q <= cfg_data_i[BASE_W-1:0];
        REG_VOLUME:   vol_q  <= cfg_data_i[VOL_W-1:0];
        REG_FM_SCALE: fms_q  <= cfg_data_i[FMS_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic              in_accept;
  logic              in_ok;
  logic [VW-1:0]     in_addr;
  logic [VOICE_W-1:0] voice_q;
  logic              voice_ok_q;
  logic [VW-1:0]     voice_addr;

  logic              ram_we;
  logic [2*PW-1:0]   ram_wdata;
  logic [2*PW-1:0]   ram_rdata;
  logic              valid_q [VOICES];

  logic signed [FMP_W-1:0] fm_prod_q;
  logic [STP_W-1:0]        step_prod_q;
  logic [SHW-1:0]          step_sh;
  logic [PW-1:0]           step_new;

  logic [2*PW-1:0]         entry;
  logic signed [OW-1:0]    ofs;
  logic [XW-1:0]           sum_x;
  logic [PW-1:0]           new_ph;
  logic                    skip;

  logic [PW-1:0]           ph_q;
  logic                    zero_q;
  logic [L-1:0]            rom_addr [2];
  logic signed [SAMPLE_W-1:0] rom_val [2];
  logic signed [SAMPLE_W-1:0] t0_q, t1_q;
  logic [FRAC_BITS-1:0]    frac_q;
  logic signed [SAMPLE_W:0] diff;
  logic signed [IP_W-1:0]  ip_q;
  logic signed [IP_W-FRAC_BITS-1:0] ip_sh;
  logic signed [IP_W-FRAC_BITS-1:0] s_sum;
  logic signed [SAMPLE_W-1:0] s_q;
  logic signed [Y_W-1:0]   y_q;
  logic signed [Y_W-16:0]  y_sh;
  logic signed [SAMPLE_W-1:0] y_sat;

  logic                    out_load;
  logic                    out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [VOICE_W-1:0]      voice_out_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_ok      = (32'(voice_i) < VOICES);
  assign in_addr    = VW'(voice_i);
  assign voice_addr = VW'(voice_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // phase update: low PW bits of phase + step + offset is the wrapped phase
  assign entry    = valid_q[voice_addr] ? ram_rdata : '0;
  assign ofs      = fm_prod_q[FMP_W-1:15];
  assign sum_x    = XW'(entry[PW-1:0]) + XW'(entry[2*PW-1:PW]) + XW'(ofs);
  assign new_ph   = sum_x[PW-1:0];
  assign skip     = !voice_ok_q || (vol_q == '0);
  assign step_sh  = step_prod_q[STP_W-1:8];
  assign step_new = PW'(step_sh);

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_wdata = {entry[2*PW-1:PW], new_ph};
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (kind_e'(kind_i))
            KIND_START:  state_d = S_START;
            KIND_SAMPLE: state_d = S_READ;
            default: ;
          endcase
        end
      end
      S_START: begin
        ram_we    = voice_ok_q;
        ram_wdata = {step_new, PW'(0)};
        state_d   = S_IDLE;
      end
      S_READ: begin
        if (skip) begin
          state_d = S_OUT;
        end else begin
          ram_we  = 1'b1;
          state_d = S_ROM;
        end
      end
      S_ROM:    state_d = S_INTERP;
      S_INTERP: state_d = S_SUM;
      S_SUM:    state_d = S_SCALE;
      S_SCALE:  state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // per-voice valid bits stand in for the all-zero reset of the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        valid_q[v] <= 1'b0;
      end
    end else begin
      if (in_accept && (kind_e'(kind_i) == KIND_END) && in_ok) begin
        valid_q[in_addr] <= 1'b0;
      end
      if (ram_we) begin
        valid_q[voice_addr] <= 1'b1;
      end
    end
  end

  fmwv_ram #(
    .WIDTH (2 * PW),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (voice_addr),
    .wdata_i (ram_wdata),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // sine lookup, quarter wave folded into the full period
  // --------------------------------------------------------------------------
  assign rom_addr[0] = ph_q[PW-1:FRAC_BITS];
  assign rom_addr[1] = ph_q[PW-1:FRAC_BITS] + L'(1);

  always_comb begin
    logic [1:0]   quad;
    logic [L-2:0] jj;
    logic [SAMPLE_W-2:0] mag;
    for (int n = 0; n < 2; n++) begin
      quad = rom_addr[n][L-1:L-2];
      if (quad[0]) begin
        jj = QN_IDX - {1'b0, rom_addr[n][L-3:0]};
      end else begin
        jj = {1'b0, rom_addr[n][L-3:0]};
      end
      mag = quarter_tbl[jj];
      if (quad[1]) begin
        rom_val[n] = -$signed({1'b0, mag});
      end else begin
        rom_val[n] = $signed({1'b0, mag});
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  assign diff  = (SAMPLE_W+1)'(t1_q) - (SAMPLE_W+1)'(t0_q);
  assign ip_sh = ip_q[IP_W-1:FRAC_BITS];
  assign s_sum = (IP_W-FRAC_BITS)'(t0_q) + ip_sh;
  assign y_sh  = y_q[Y_W-1:15];

  always_comb begin
    if (y_sh > (Y_W-15)'(32767)) begin
      y_sat = 16'sh7fff;
    end else if (y_sh < -(Y_W-15)'(32768)) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          voice_q     <= voice_i;
          voice_ok_q  <= in_ok;
          fm_prod_q   <= freq_mod_i * $signed({1'b0, fms_q});
          step_prod_q <= base_q * voice_ratio_i;
        end
      end
      S_READ: begin
        ph_q   <= new_ph;
        zero_q <= skip;
      end
      S_ROM: begin
        t0_q   <= rom_val[0];
        t1_q   <= rom_val[1];
        frac_q <= ph_q[FRAC_BITS-1:0];
      end
      S_INTERP: ip_q <= diff * $signed({1'b0, frac_q});
      S_SUM:    s_q  <= s_sum[SAMPLE_W-1:0];
      S_SCALE:  y_q  <= s_q * $signed({1'b0, vol_q});
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q    <= zero_q ? '0 : y_sat;
      voice_out_q <= voice_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign voice_out_o = voice_out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_sample_reads_store, clk_i, rst_ni, in_accept && (kind_i == KIND_SAMPLE), state_q == S_READ, "sample transaction did not start a store read")
  `ASSERT_ON_CLK(a_write_state, clk_i, rst_ni, ram_we |-> (state_q == S_START || state_q == S_READ), "voice store written outside a write state")
  `ASSERT_NEXT(a_silent_skips, clk_i, rst_ni, (state_q == S_READ) && (vol_q == '0), (state_q == S_OUT) && zero_q, "zero volume did not take the silent path")
  `ASSERT_NEXT(a_result_voice, clk_i, rst_ni, out_load, out_valid_q && (voice_out_q == $past(voice_q)), "result loaded with the wrong voice")

endmodule

`default_nettype wire
